>>> rtl/nv21rgb_pkg.sv
// ----------------------------------------------------------------------------
// nv21rgb_pkg
// Shared types, register indexes and conversion constants for the NV21 frame
// store with RGB888 readout.
// ----------------------------------------------------------------------------
package nv21rgb_pkg;

    // Operation codes carried in a request.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATE       = 2'd2;

    // Register reset values.
    localparam logic [9:0] RESET_WIDTH  = 10'd640;
    localparam logic [8:0] RESET_HEIGHT = 9'd480;

    // Fixed-point coefficients, 16 fraction bits.
    localparam int PROD_W = 27;
    localparam int SUM_W  = 28;
    localparam logic signed [PROD_W-1:0] K_RV = 27'sd89831;
    localparam logic signed [PROD_W-1:0] K_GV = 27'sd45744;
    localparam logic signed [PROD_W-1:0] K_GU = 27'sd22127;
    localparam logic signed [PROD_W-1:0] K_BU = 27'sd113538;
    localparam logic [8:0] CHROMA_BIAS = 9'd128;

    // Request and response payloads.
    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic [8:0] out_row;
        logic [9:0] out_col;
    } request_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_ready;
    } response_t;

    // Frame store read select and read data latch select.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_Y,
        RD_V,
        RD_U
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    capture;
        logic    clamp;
        logic    mult;
        logic    addr;
        rd_sel_t rd_sel;
        rd_sel_t lat_sel;
        logic    prod;
        logic    emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic geom_ready;
        logic out_free;
    } dp_status_t;

    // Clamp a Q16 sum to an 8-bit channel value, truncating the fraction.
    function automatic logic [7:0] to_byte(input logic signed [SUM_W-1:0] s);
        logic [7:0] v;
        if (s[SUM_W-1]) begin
            v = 8'd0;
        end else if (|s[SUM_W-2:24]) begin
            v = 8'hFF;
        end else begin
            v = s[23:16];
        end
        return v;
    endfunction

endpackage

>>> rtl/nv21rgb_stream_if.sv
// ----------------------------------------------------------------------------
// nv21rgb_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface nv21rgb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/nv21_frame_to_rgb_converter.sv
// Loads finish in the accepting cycle; a load may follow a load in every
// cycle while the geometry is settled. A read clamps its coordinates, forms
// addresses and fetches Y, V and U in turn through the single frame store
// port, then forms products and sums; no request is taken until the result
// enters the free output register. Requests wait after reset and after every
// register write while the geometry settles; reset clears the load position and frame flag.
// ----------------------------------------------------------------------------
// nv21_frame_to_rgb_converter
// NV21 frame store loaded one byte per transfer, with RGB888 pixel readout.
// ----------------------------------------------------------------------------
module nv21_frame_to_rgb_converter
    import nv21rgb_pkg::*;
#(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    nv21rgb_stream_if.sink         request,
    nv21rgb_stream_if.source       response
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    nv21rgb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (request.valid),
        .req_operation (request.payload.operation),
        .req_ready     (request.ready),
        .status        (status),
        .cmd           (cmd)
    );

    // Storage and arithmetic.
    nv21rgb_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_payload (request.payload),
        .rsp_valid   (response.valid),
        .rsp_ready   (response.ready),
        .rsp_payload (response.payload),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

>>> rtl/nv21rgb_ctrl.sv
// ----------------------------------------------------------------------------
// nv21rgb_ctrl
// Sequencer for request handling: loads finish in the accepting cycle, reads
// step through address generation, three store fetches and the conversion.
// ----------------------------------------------------------------------------
module nv21rgb_ctrl
    import nv21rgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_operation,
    output logic       req_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_MULT,
        S_ADDR,
        S_RD_Y,
        S_RD_V,
        S_RD_U,
        S_LAT_U,
        S_PROD,
        S_SUM
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A request is taken only in idle once the frame geometry has settled.
    assign req_ready = (state_reg == S_IDLE) && status.geom_ready;
    assign accept    = req_ready && req_valid;

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_sel  = RD_NONE;
        cmd.lat_sel = RD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    if (req_operation == OP_READ) begin
                        cmd.capture = 1'b1;
                        state_next  = S_CLAMP;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = S_RD_Y;
            end
            S_RD_Y:
            begin
                cmd.rd_sel = RD_Y;
                state_next = S_RD_V;
            end
            S_RD_V:
            begin
                cmd.rd_sel  = RD_V;
                cmd.lat_sel = RD_Y;
                state_next  = S_RD_U;
            end
            S_RD_U:
            begin
                cmd.rd_sel  = RD_U;
                cmd.lat_sel = RD_V;
                state_next  = S_LAT_U;
            end
            S_LAT_U:
            begin
                cmd.lat_sel = RD_U;
                state_next  = S_PROD;
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // Hold the result until the output register is free.
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/nv21rgb_dpath.sv
// ----------------------------------------------------------------------------
// nv21rgb_dpath
// Frame store, configuration registers, load pointer, read address
// generation, YUV to RGB conversion and the response register.
// ----------------------------------------------------------------------------
module nv21rgb_dpath
    import nv21rgb_pkg::*;
#(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  request_t               req_payload,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output response_t              rsp_payload,
    input  dp_cmd_t                cmd,
    output dp_status_t             status
);

    localparam int STORE_DEPTH = (MAX_WIDTH * MAX_HEIGHT * 3) / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SIZE_W      = $clog2(STORE_DEPTH + 1);
    localparam int WCAP        = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
    localparam int HCAP        = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam logic [9:0] WCAP_V = WCAP[9:0];
    localparam logic [8:0] HCAP_V = HCAP[8:0];

    // Configuration registers.
    logic [9:0] frame_width_reg;
    logic [8:0] frame_height_reg;
    logic       rotate_reg;
    logic [1:0] settle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_width_reg  <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
            rotate_reg       <= 1'b0;
            settle_reg       <= 2'd3;
        end else begin
            if (cfg_write) begin
                settle_reg <= 2'd3;
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[8:0];
                    CFG_ROTATE:       rotate_reg       <= cfg_data[0];
                    default:          ;
                endcase
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // Effective frame size: saturate, force even, at least two.
    logic [9:0]        w_sat;
    logic [8:0]        h_sat;
    logic [9:0]        w_eff_reg;
    logic [8:0]        h_eff_reg;
    logic [SIZE_W-1:0] luma_size_reg;
    logic [SIZE_W-1:0] frame_size_reg;

    always_comb
    begin
        w_sat = (frame_width_reg > WCAP_V) ? WCAP_V : frame_width_reg;
        w_sat[0] = 1'b0;
        if (w_sat < 10'd2) begin
            w_sat = 10'd2;
        end
        h_sat = (frame_height_reg > HCAP_V) ? HCAP_V : frame_height_reg;
        h_sat[0] = 1'b0;
        if (h_sat < 9'd2) begin
            h_sat = 9'd2;
        end
    end

    // Geometry pipeline: effective size, then luma size, then frame size registers.
    always_ff @(posedge clk)
    begin
        w_eff_reg      <= w_sat;
        h_eff_reg      <= h_sat;
        luma_size_reg  <= SIZE_W'(w_eff_reg * h_eff_reg);
        frame_size_reg <= luma_size_reg + (luma_size_reg >> 1);
    end

    // Load pointer and frame-complete flag.
    logic [SIZE_W-1:0] pos_reg;
    logic [SIZE_W-1:0] pos_cur;
    logic [SIZE_W-1:0] pos_inc;
    logic              full_reg;

    assign pos_cur = (pos_reg >= frame_size_reg) ? '0 : pos_reg;
    assign pos_inc = pos_cur + SIZE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            full_reg <= 1'b0;
        end else if (cmd.load) begin
            if (pos_inc >= frame_size_reg) begin
                pos_reg  <= '0;
                full_reg <= 1'b1;
            end else begin
                pos_reg <= pos_inc;
            end
        end
    end

    // Read coordinates: capture, clamp to the frame, optional half turn.
    logic [8:0]  row_reg;
    logic [9:0]  col_reg;
    logic [8:0]  h_last;
    logic [9:0]  w_last;
    logic [8:0]  row_clamped;
    logic [9:0]  col_clamped;

    assign h_last      = h_eff_reg - 9'd1;
    assign w_last      = w_eff_reg - 10'd1;
    assign row_clamped = (row_reg > h_last) ? h_last : row_reg;
    assign col_clamped = (col_reg > w_last) ? w_last : col_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            row_reg <= req_payload.out_row;
            col_reg <= req_payload.out_col;
        end else if (cmd.clamp) begin
            row_reg <= rotate_reg ? (h_last - row_clamped) : row_clamped;
            col_reg <= rotate_reg ? (w_last - col_clamped) : col_clamped;
        end
    end

    // Address generation: row offsets, then luma and chroma addresses.
    logic [18:0]       row_off_reg;
    logic [18:0]       pair_off_reg;
    logic [ADDR_W-1:0] y_addr_reg;
    logic [ADDR_W-1:0] c_addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mult) begin
            row_off_reg  <= row_reg * w_eff_reg;
            pair_off_reg <= {1'b0, row_reg[8:1]} * w_eff_reg;
        end
        if (cmd.addr) begin
            y_addr_reg <= ADDR_W'(row_off_reg + 19'(col_reg));
            c_addr_reg <= ADDR_W'(luma_size_reg) + ADDR_W'(pair_off_reg)
                          + ADDR_W'({col_reg[9:1], 1'b0});
        end
    end

    // Frame store: one port, written by loads, read with registered data.
    logic [7:0]        store_mem [STORE_DEPTH];
    logic [7:0]        store_q_reg;
    logic [ADDR_W-1:0] rd_addr;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_Y:    rd_addr = y_addr_reg;
            RD_V:    rd_addr = c_addr_reg;
            RD_U:    rd_addr = {c_addr_reg[ADDR_W-1:1], 1'b1};
            default: rd_addr = y_addr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            store_mem[pos_cur[ADDR_W-1:0]] <= req_payload.data_byte;
        end
        if (cmd.rd_sel != RD_NONE) begin
            store_q_reg <= store_mem[rd_addr];
        end
    end

    // Latch the fetched samples.
    logic [7:0] y_reg;
    logic [7:0] v_reg;
    logic [7:0] u_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.lat_sel)
            RD_Y:    y_reg <= store_q_reg;
            RD_V:    v_reg <= store_q_reg;
            RD_U:    u_reg <= store_q_reg;
            default: ;
        endcase
    end

    // Coefficient products.
    logic signed [8:0]        dv;
    logic signed [8:0]        du;
    logic signed [PROD_W-1:0] rv_reg;
    logic signed [PROD_W-1:0] gv_reg;
    logic signed [PROD_W-1:0] gu_reg;
    logic signed [PROD_W-1:0] bu_reg;

    assign dv = $signed({1'b0, v_reg} - CHROMA_BIAS);
    assign du = $signed({1'b0, u_reg} - CHROMA_BIAS);

    always_ff @(posedge clk)
    begin
        if (cmd.prod) begin
            rv_reg <= K_RV * PROD_W'(dv);
            gv_reg <= K_GV * PROD_W'(dv);
            gu_reg <= K_GU * PROD_W'(dv == dv ? du : du);
            bu_reg <= K_BU * PROD_W'(du);
        end
    end

    // Sums in Q16 and channel clamping.
    logic signed [SUM_W-1:0] y_q16;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] g_sum;
    logic signed [SUM_W-1:0] b_sum;

    assign y_q16 = $signed({4'b0000, y_reg, 16'h0000});
    assign r_sum = y_q16 + SUM_W'(rv_reg);
    assign g_sum = y_q16 - SUM_W'(gv_reg) - SUM_W'(gu_reg);
    assign b_sum = y_q16 + SUM_W'(bu_reg);

    // Response register.
    logic      rsp_valid_reg;
    response_t rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            rsp_valid_reg <= 1'b1;
        end else if (rsp_ready) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            rsp_data_reg.red         <= to_byte(r_sum);
            rsp_data_reg.green       <= to_byte(g_sum);
            rsp_data_reg.blue        <= to_byte(b_sum);
            rsp_data_reg.frame_ready <= full_reg;
        end
    end

    assign rsp_valid         = rsp_valid_reg;
    assign rsp_payload       = rsp_data_reg;
    assign status.geom_ready = (settle_reg == 2'd0);
    assign status.out_free   = !rsp_valid_reg || rsp_ready;

endmodule

>>> rtl/nv21rgb_checker.sv
// ----------------------------------------------------------------------------
// nv21rgb_checker
// Port-level checks for the NV21 converter, attached by bind.
// ----------------------------------------------------------------------------
module nv21rgb_checker
    import nv21rgb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cfg_write,
    input logic      req_valid,
    input logic      req_ready,
    input logic      req_operation,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input response_t rsp_payload
);

    // A response waiting for its transfer stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transfer");

    // A waiting response keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_payload))
        else $error("response payload changed while stalled");

    // A read occupies the block: no request is taken right after one.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_operation == OP_READ |=> !req_ready)
        else $error("request taken while a read is in progress");

    // A register write holds off requests while the geometry settles.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !req_ready)
        else $error("request taken right after a register write");

    // A load never produces a response.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_operation == OP_LOAD |=> !$rose(rsp_valid))
        else $error("response raised by a load");

endmodule

bind nv21_frame_to_rgb_converter nv21rgb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write     (cfg_write),
    .req_valid     (request.valid),
    .req_ready     (request.ready),
    .req_operation (request.payload.operation),
    .rsp_valid     (response.valid),
    .rsp_ready     (response.ready),
    .rsp_payload   (response.payload)
);

>>> tb/nv21_frame_to_rgb_converter_tb.sv
// ----------------------------------------------------------------------------
// nv21_frame_to_rgb_converter_tb
// Loads NV21 frames into the converter one byte per transfer and reads
// back pixels. A scoreboard keeps its own copy of the frame store and
// geometry registers, predicts each RGB pixel in Q16 fixed point, and
// checks every response field by field. Frame sizes run from 2x2 up to
// the full width and height. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module nv21_frame_to_rgb_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nv21rgb_pkg::*;

    localparam int unsigned MAX_W        = 640;
    localparam int unsigned MAX_H        = 480;
    localparam int unsigned STORE_DEPTH  = MAX_W * MAX_H * 3 / 2;
    localparam longint      COEF_RV      = 89831;
    localparam longint      COEF_GV      = 45744;
    localparam longint      COEF_GU      = 22127;
    localparam longint      COEF_BU      = 113538;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned HOLD_AFTER     = 20;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    // Tracks the frame store and predicts the RGB value of every read.
    class rgb_pixel_scoreboard;
        logic [7:0]  store_bytes [STORE_DEPTH];
        bit          store_valid [STORE_DEPTH];
        int unsigned load_pos;
        bit          frame_full;
        int unsigned width_reg;
        int unsigned height_reg;
        bit          rotate_reg;
        response_t   pending_pixels [$];
        int unsigned mismatches;
        int unsigned pixels_checked;
        int unsigned bytes_loaded;

        function new();
            load_pos       = 0;
            frame_full     = 1'b0;
            width_reg      = RESET_WIDTH;
            height_reg     = RESET_HEIGHT;
            rotate_reg     = 1'b0;
            mismatches     = 0;
            pixels_checked = 0;
            bytes_loaded   = 0;
        endfunction

        // A size register saturates to the legal range and drops bit 0.
        function int unsigned active_dim(int unsigned v, int unsigned maxv);
            if (v > maxv)
            begin
                v = maxv;
            end
            v = v & ~32'd1;
            if (v < 2)
            begin
                v = 2;
            end
            return v;
        endfunction

        function int unsigned active_width();
            return active_dim(width_reg, MAX_W);
        endfunction

        function int unsigned active_height();
            return active_dim(height_reg, MAX_H);
        endfunction

        function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg  = value;
                CFG_FRAME_HEIGHT: height_reg = value[8:0];
                CFG_ROTATE:       rotate_reg = value[0];
                default:          ;
            endcase
        endfunction

        // Store addresses of the luma byte and the V,U pair behind a pixel.
        function void locate(input int unsigned row, input int unsigned col,
                             output int unsigned y_addr, output int unsigned c_addr);
            int unsigned w;
            int unsigned h;
            w = active_width();
            h = active_height();
            if (row > h - 1)
            begin
                row = h - 1;
            end
            if (col > w - 1)
            begin
                col = w - 1;
            end
            if (rotate_reg)
            begin
                row = h - 1 - row;
                col = w - 1 - col;
            end
            y_addr = row * w + col;
            c_addr = w * h + (row / 2) * w + (col & ~32'd1);
        endfunction

        function bit readable(int unsigned row, int unsigned col);
            int unsigned y_addr;
            int unsigned c_addr;
            locate(row, col, y_addr, c_addr);
            return store_valid[y_addr] && store_valid[c_addr] && store_valid[c_addr + 1];
        endfunction

        function logic [7:0] clamp_channel(longint acc);
            longint scaled;
            if (acc < 0)
            begin
                return 8'd0;
            end
            scaled = acc >>> 16;
            if (scaled > 255)
            begin
                return 8'hFF;
            end
            return scaled[7:0];
        endfunction

        function response_t convert_pixel(int unsigned row, int unsigned col);
            int unsigned y_addr;
            int unsigned c_addr;
            longint      luma;
            longint      dv;
            longint      du;
            response_t   pix;
            locate(row, col, y_addr, c_addr);
            luma = store_bytes[y_addr];
            dv   = store_bytes[c_addr];
            du   = store_bytes[c_addr + 1];
            dv   = dv - 128;
            du   = du - 128;
            luma = luma * 65536;
            pix.red         = clamp_channel(luma + COEF_RV * dv);
            pix.green       = clamp_channel(luma - COEF_GV * dv - COEF_GU * du);
            pix.blue        = clamp_channel(luma + COEF_BU * du);
            pix.frame_ready = frame_full;
            return pix;
        endfunction

        // Called for every accepted request transfer.
        function void note_request(request_t item);
            int unsigned frame_size;
            frame_size = active_width() * active_height() * 3 / 2;
            if (item.operation == OP_LOAD)
            begin
                if (load_pos >= frame_size)
                begin
                    load_pos = 0;
                end
                store_bytes[load_pos] = item.data_byte;
                store_valid[load_pos] = 1'b1;
                load_pos++;
                if (load_pos >= frame_size)
                begin
                    load_pos   = 0;
                    frame_full = 1'b1;
                end
                bytes_loaded++;
            end
            else
            begin
                pending_pixels.push_back(convert_pixel(item.out_row, item.out_col));
            end
        endfunction

        // Called for every accepted response transfer.
        function void check_pixel(response_t got);
            response_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("Pixel response with no read outstanding: %p", got);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.red !== want.red)
            begin
                $error("red: expected %0d, actual %0d", want.red, got.red);
                mismatches++;
            end
            if (got.green !== want.green)
            begin
                $error("green: expected %0d, actual %0d", want.green, got.green);
                mismatches++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                mismatches++;
            end
            if (got.frame_ready !== want.frame_ready)
            begin
                $error("frame_ready: expected %0d, actual %0d",
                       want.frame_ready, got.frame_ready);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    nv21rgb_stream_if #(.payload_t(request_t))  req_if ();
    nv21rgb_stream_if #(.payload_t(response_t)) resp_if ();

    rgb_pixel_scoreboard board = new();

    bit          gap_on   = 1'b0;
    bit          stall_on = 1'b0;
    bit          steady   = 1'b0;
    int unsigned settings_used = 0;

    nv21_frame_to_rgb_converter #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .request  (req_if),
        .response (resp_if)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic request_t load_item(input logic [7:0] value);
        request_t item;
        item.operation = OP_LOAD;
        item.data_byte = value;
        item.out_row   = 9'($urandom);
        item.out_col   = 10'($urandom);
        return item;
    endfunction

    function automatic request_t read_item(input int unsigned row, input int unsigned col);
        request_t item;
        item.operation = OP_READ;
        item.data_byte = 8'($urandom);
        item.out_row   = 9'(row);
        item.out_col   = 10'(col);
        return item;
    endfunction

    // Offers one request and waits for its transfer; valid stays high after.
    task automatic push_request(input request_t item);
        if (gap_on && $urandom_range(0, 5) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        board.note_request(item);
    endtask

    // Reads a pixel whose store entries are all loaded, if one is found.
    task automatic issue_read();
        int unsigned row;
        int unsigned col;
        int unsigned tries;
        bit          found;
        found = 1'b0;
        for (tries = 0; tries < 24 && !found; tries++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                row = $urandom_range(0, 511);
                col = $urandom_range(0, 1023);
            end
            else
            begin
                row = $urandom_range(0, board.active_height() - 1);
                col = $urandom_range(0, board.active_width() - 1);
            end
            found = board.readable(row, col);
        end
        if (found)
        begin
            push_request(read_item(row, col));
        end
    endtask

    // Waits until every read has answered and the block has gone quiet.
    task automatic settle_block();
        while (board.pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.note_config(idx, value);
    endtask

    // Rewrites all three registers back to back once the block is idle.
    task automatic set_geometry(input int unsigned wv, input int unsigned hv, input bit rot);
        logic [CFG_DATA_W-1:0] rot_word;
        settle_block();
        rot_word    = CFG_DATA_W'($urandom);
        rot_word[0] = rot;
        write_register(CFG_FRAME_WIDTH, CFG_DATA_W'(wv));
        write_register(CFG_FRAME_HEIGHT, CFG_DATA_W'(hv));
        write_register(CFG_ROTATE, rot_word);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // One geometry setting: frame bytes in order with reads mixed in.
    task automatic run_phase(input int unsigned wv, input int unsigned hv, input bit rot,
                             input int unsigned loads, input int unsigned reads);
        int unsigned loads_left;
        int unsigned reads_left;
        set_geometry(wv, hv, rot);
        if (!steady)
        begin
            gap_on   = $urandom_range(0, 2) != 0;
            stall_on = $urandom_range(0, 2) != 0;
        end
        loads_left = loads;
        reads_left = reads;
        while (loads_left + reads_left > 0)
        begin
            if ($urandom_range(1, loads_left + reads_left) <= reads_left)
            begin
                issue_read();
                reads_left--;
            end
            else
            begin
                push_request(load_item(8'($urandom)));
                loads_left--;
            end
        end
        req_if.valid <= 1'b0;
    endtask

    // Response side: checks each transfer and stalls in bursts.
    initial
    begin : pixel_sink
        int unsigned stall_left;
        bit          held;
        stall_left = 0;
        held       = 1'b0;
        resp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (resp_if.valid && resp_if.ready)
            begin
                board.check_pixel(resp_if.payload);
            end
            // One long hold-off lets the block back up into its input.
            if (!held && board.pixels_checked == HOLD_AFTER)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && stall_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                resp_if.ready <= 1'b0;
            end
            else
            begin
                resp_if.ready <= 1'b1;
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (resp_if.valid && resp_if.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Main stimulus.
    initial
    begin : stimulus
        logic [7:0]  pattern [12];
        int unsigned w_reg;
        int unsigned h_reg;
        int unsigned frame_size;

        pattern = '{8'd0, 8'd255, 8'd128, 8'd64, 8'd255, 8'd0, 8'd16, 8'd235,
                    8'd255, 8'd0, 8'd0, 8'd255};
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // 4x2 frame. Reads before the last chroma pair still see no full frame.
        // The first pair is V high, U low and the second the reverse.
        set_geometry(4, 2, 1'b0);
        for (int i = 0; i < 10; i++)
        begin
            push_request(load_item(pattern[i]));
        end
        push_request(read_item(0, 0));
        push_request(read_item(0, 1));
        push_request(read_item(1, 0));
        push_request(read_item(1, 1));
        for (int i = 10; i < 12; i++)
        begin
            push_request(load_item(pattern[i]));
        end
        push_request(read_item(0, 2));
        push_request(read_item(1, 3));
        push_request(read_item(511, 1023));
        req_if.valid <= 1'b0;

        // The same frame read through the half-turn rotation.
        set_geometry(4, 2, 1'b1);
        push_request(read_item(0, 0));
        push_request(read_item(1, 3));
        push_request(read_item(300, 0));
        req_if.valid <= 1'b0;

        // Small frames, including a partial frame before a size change.
        run_phase(8, 4, 1'b0, 48, 30);
        run_phase(8, 4, 1'b1, 20, 30);
        run_phase(6, 6, 1'b1, 70, 40);

        // Narrowest and widest frames with saturating register values.
        run_phase(1, 511, 1'b0, 1100, 40);
        run_phase(1023, 0, 1'b1, 820, 40);

        // Random small geometries, odd and undersized values among them.
        for (int p = 0; p < 10; p++)
        begin
            w_reg      = $urandom_range(0, 13);
            h_reg      = $urandom_range(0, 9);
            frame_size = board.active_dim(w_reg, MAX_W) * board.active_dim(h_reg, MAX_H) * 3 / 2;
            run_phase(w_reg, h_reg, $urandom_range(0, 1),
                      $urandom_range(frame_size / 2, frame_size + frame_size / 2),
                      $urandom_range(20, 40));
        end

        // Closing stretch at full rate on both sides.
        steady   = 1'b1;
        gap_on   = 1'b0;
        stall_on = 1'b0;
        run_phase(10, 4, 1'b1, 60, 30);

        while (board.pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Loaded %0d frame bytes and checked %0d converted pixels",
                 board.bytes_loaded, board.pixels_checked);
        $display("across %0d geometry settings from 2x2 up to 640 wide and 480 high.",
                 settings_used);
        if (board.mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
